// File: design/lhrp_pkg.sv
package lhrp_pkg;

  // Fixed field widths
  localparam int unsigned PC_W      = 7;
  localparam int unsigned SEED_W    = 64;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned FIELD_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;

  localparam int unsigned MAX_POINTS_DEF = 64;

  localparam logic [SEED_W-1:0] SEED_CONST  = 64'd88172645463325252;
  localparam logic [PC_W-1:0]   PC_RESET    = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_TIME   = 2'd1;
  // no register behind this index; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_STEP,
    ST_DIV,
    ST_SWAP_RD,
    ST_SWAP_WJ,
    ST_SWAP_WI,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic fill;
    logic step;
    logic div;
    logic swap_rd;
    logic swap_wj;
    logic swap_wi;
    logic emit_rd;
    logic emit_adv;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic i_zero;
    logic i_one;
    logic div_done;
    logic emit_last;
  } status_t;

endpackage

// File: design/lhrp_ctrl.sv
module lhrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lhrp_pkg::status_t status_i,
  output lhrp_pkg::cmd_t    cmd_o
);
  import lhrp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.fill_last) begin
          state_d = status_i.i_zero ? ST_EMIT_RD : ST_STEP;
        end
      end
      ST_STEP: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_SWAP_RD;
      end
      ST_SWAP_RD: state_d = ST_SWAP_WJ;
      ST_SWAP_WJ: state_d = ST_SWAP_WI;
      ST_SWAP_WI: state_d = status_i.i_one ? ST_EMIT_RD : ST_STEP;
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i) state_d = status_i.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_FILL:    cmd_o.fill    = 1'b1;
      ST_STEP:    cmd_o.step    = 1'b1;
      ST_DIV:     cmd_o.div     = 1'b1;
      ST_SWAP_RD: cmd_o.swap_rd = 1'b1;
      ST_SWAP_WJ: cmd_o.swap_wj = 1'b1;
      ST_SWAP_WI: cmd_o.swap_wi = 1'b1;
      ST_EMIT_RD: cmd_o.emit_rd = 1'b1;
      ST_EMIT: begin
        out_valid_o    = 1'b1;
        cmd_o.emit_adv = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

// File: design/lhrp_dpath.sv
module lhrp_dpath #(
  parameter int unsigned MAX_POINTS = lhrp_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lhrp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lhrp_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [lhrp_pkg::DIM_W-1:0]       dim_index_i,
  input  lhrp_pkg::cmd_t                   cmd_i,
  output lhrp_pkg::status_t                status_o,
  output logic [lhrp_pkg::FIELD_W-1:0]     slot_o,
  output logic [lhrp_pkg::FIELD_W-1:0]     value_o,
  output logic                             last_o
);
  import lhrp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;
  localparam int unsigned BIT_W = $clog2(SEED_W);

  function automatic logic [SEED_W-1:0] xs_next(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // config registers
  logic [PC_W-1:0]   point_count_q;
  logic [SEED_W-1:0] seed_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PC_RESET;
      seed_time_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINT_COUNT: point_count_q <= cfg_data_i[PC_W-1:0];
        CFG_SEED_TIME:   seed_time_q   <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // row length, clamped to 1..MAX_POINTS
  logic [CMP_W-1:0] pc_ext, n_sat;
  logic [CNT_W-1:0] n_row;
  logic [IDX_W-1:0] n_m1_row;

  always_comb begin
    pc_ext = CMP_W'(point_count_q);
    if (pc_ext == '0) begin
      n_sat = CMP_W'(1);
    end else if (pc_ext > CMP_W'(MAX_POINTS)) begin
      n_sat = CMP_W'(MAX_POINTS);
    end else begin
      n_sat = pc_ext;
    end
    n_row    = n_sat[CNT_W-1:0];
    n_m1_row = IDX_W'(n_row - CNT_W'(1));
  end

  // counters
  logic [IDX_W-1:0] n_m1_q, k_q, i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_m1_q <= '0;
      k_q    <= '0;
      i_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        n_m1_q <= n_m1_row;
        i_q    <= n_m1_row;
        k_q    <= '0;
      end else if (cmd_i.fill) begin
        k_q <= (k_q == n_m1_q) ? '0 : k_q + IDX_W'(1);
      end else if (cmd_i.emit_adv) begin
        k_q <= k_q + IDX_W'(1);
      end
      if (cmd_i.swap_wi) i_q <= i_q - IDX_W'(1);
    end
  end

  // generator and remainder unit
  logic [SEED_W-1:0] x_q, x_new, sh_q;
  logic [CNT_W-1:0]  rem_q, div_q;
  logic [BIT_W-1:0]  bit_q;
  logic [CNT_W:0]    trial, trial_sub;

  assign x_new     = xs_next(x_q);
  assign trial     = {rem_q, sh_q[SEED_W-1]};
  assign trial_sub = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      bit_q <= '0;
    end else if (cmd_i.load) begin
      x_q <= SEED_CONST ^ SEED_W'(dim_index_i) ^ seed_time_q;
    end else if (cmd_i.step) begin
      x_q   <= x_new;
      bit_q <= BIT_W'(SEED_W - 1);
    end else if (cmd_i.div) begin
      bit_q <= bit_q - BIT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      sh_q  <= x_new;
      rem_q <= '0;
      div_q <= CNT_W'(i_q) + CNT_W'(1);
    end else if (cmd_i.div) begin
      sh_q  <= sh_q << 1;
      rem_q <= (trial >= {1'b0, div_q}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // permutation store
  logic [IDX_W-1:0] mem_q [MAX_POINTS];
  logic [IDX_W-1:0] rd_a_q, rd_b_q;
  logic [IDX_W-1:0] j_idx, wr_addr, wr_data, rd_a_addr;
  logic             wr_en;

  assign j_idx     = rem_q[IDX_W-1:0];
  assign rd_a_addr = cmd_i.emit_rd ? k_q : i_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_q;
    wr_data = k_q;
    if (cmd_i.fill) begin
      wr_en = 1'b1;
    end else if (cmd_i.swap_wj) begin
      wr_en   = 1'b1;
      wr_addr = j_idx;
      wr_data = rd_a_q;
    end else if (cmd_i.swap_wi) begin
      wr_en   = 1'b1;
      wr_addr = i_q;
      wr_data = rd_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.swap_rd || cmd_i.emit_rd) rd_a_q <= mem_q[rd_a_addr];
    if (cmd_i.swap_rd) rd_b_q <= mem_q[j_idx];
  end

  // result word
  logic [IDX_W+FIELD_W-1:0] slot_ext, value_ext;

  assign slot_ext  = {{FIELD_W{1'b0}}, k_q};
  assign value_ext = {{FIELD_W{1'b0}}, rd_a_q};
  assign slot_o    = slot_ext[FIELD_W-1:0];
  assign value_o   = value_ext[FIELD_W-1:0];
  assign last_o    = (k_q == n_m1_q);

  assign status_o.fill_last = (k_q == n_m1_q);
  assign status_o.i_zero    = (i_q == '0);
  assign status_o.i_one     = (i_q == IDX_W'(1));
  assign status_o.div_done  = (bit_q == '0);
  assign status_o.emit_last = (k_q == n_m1_q);

endmodule

// File: design/latin_hypercube_row_permuter.sv
// Latin hypercube row permuter.
// Input channel (in_valid_i/in_ready_o, dim_index_i): one word asks for one
// row. The row is a random permutation of 0..N-1, N = point_count clamped to
// 1..MAX_POINTS, drawn by a Fisher-Yates shuffle driven by a 64-bit xorshift
// generator seeded with a fixed constant ^ dim_index ^ seed_time.
// Output channel (out_valid_o/out_ready_i): N words in slot order, each with
// slot_o, value_o and last_o set on the final one.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 point_count,
// 1 seed_time); write only while the block is idle.
// Operation: one row at a time. Fill writes 0..N-1 to the store; each of
// the N-1 swaps does 1 generator step, 64 restoring remainder steps, one
// two-port read and two writes; emit reads each word, then presents it.
// in_ready_o is high only while idle. A stalled receiver holds the current
// word steady; the block simply waits.
// Reset: point_count = 64, seed_time = 0, controller idle. The store needs no
// clearing since every row rewrites it before reading.
module latin_hypercube_row_permuter #(
  parameter int unsigned MAX_POINTS = lhrp_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lhrp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lhrp_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lhrp_pkg::DIM_W-1:0]       dim_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lhrp_pkg::FIELD_W-1:0]     slot_o,
  output logic [lhrp_pkg::FIELD_W-1:0]     value_o,
  output logic                             last_o
);
  import lhrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  lhrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // store, generator, remainder unit, config registers
  lhrp_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .dim_index_i (dim_index_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .slot_o      (slot_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule
